### rtl/core/nns_pkg.sv
// Shared types and constants for the nearest-neighbour scaler core.
// Used by nns_div and nearest_neighbor_image_scaler_core; no dependencies.
`default_nettype none

package nns_pkg;

  // field widths fixed by the register and port definitions
  localparam int SRC_W     = 9;                // source dimension register
  localparam int DIM_W     = 16;               // output dimension / counters
  localparam int CFG_W     = 16;               // widest configuration register
  localparam int CFG_IDX_W = 2;
  localparam int POS_W     = 16;               // load position
  localparam int PIX_W     = 24;               // one BGR pixel
  localparam int NUM_W     = DIM_W + SRC_W;    // product of a counter and a dimension
  localparam int IDX_W     = 2 * SRC_W;        // row * width + column
  localparam int DIV_CNT_W = $clog2(SRC_W);

  localparam logic [DIM_W-1:0] DIM_MAX = '1;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SRC_WIDTH   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SRC_HEIGHT  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SCALE       = 2'd2;

  localparam logic [SRC_W-1:0] SRC_WIDTH_RST  = 9'd256;
  localparam logic [SRC_W-1:0] SRC_HEIGHT_RST = 9'd256;
  localparam logic [DIM_W-1:0] SCALE_RST      = 16'd256;

  // request to the shared divider: quotient must fit in SRC_W bits
  typedef struct packed {
    logic             start;
    logic [NUM_W-1:0] dividend;
    logic [DIM_W-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic             done;
    logic [SRC_W-1:0] quotient;
  } div_rsp_t;

endpackage

`default_nettype wire

### rtl/core/nns_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module nns_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 65536
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

### rtl/core/nns_div.sv
// Shared restoring divider, one quotient bit per cycle.
// Depends on nns_pkg for widths and the request/response structs.
`default_nettype none

module nns_div (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire nns_pkg::div_req_t req,
  output nns_pkg::div_rsp_t      rsp
);

  logic [nns_pkg::DIM_W-1:0]     rem_r;
  logic [nns_pkg::SRC_W-1:0]     num_r;
  logic [nns_pkg::DIM_W-1:0]     dsr_r;
  logic [nns_pkg::DIV_CNT_W-1:0] cnt_r;
  logic                          busy_r;
  logic                          done_r;

  logic [nns_pkg::DIM_W:0]   trial;
  logic [nns_pkg::DIM_W:0]   diff;
  logic                      ge;
  logic [nns_pkg::DIM_W-1:0] rem_nxt;

  // shift the next dividend bit into the partial remainder
  assign trial   = {rem_r, num_r[nns_pkg::SRC_W-1]};
  assign ge      = trial >= {1'b0, dsr_r};
  assign diff    = trial - {1'b0, dsr_r};
  assign rem_nxt = ge ? diff[nns_pkg::DIM_W-1:0] : trial[nns_pkg::DIM_W-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        // upper part of the dividend is below the divisor by construction
        rem_r  <= req.dividend[nns_pkg::NUM_W-1:nns_pkg::SRC_W];
        num_r  <= req.dividend[nns_pkg::SRC_W-1:0];
        dsr_r  <= req.divisor;
        cnt_r  <= '0;
        busy_r <= 1'b1;
      end else if (busy_r) begin
        rem_r <= rem_nxt;
        num_r <= {num_r[nns_pkg::SRC_W-2:0], ge};
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == nns_pkg::DIV_CNT_W'(nns_pkg::SRC_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign rsp.done     = done_r;
  assign rsp.quotient = num_r;

  a_no_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    req.start |-> !busy_r)
    else $error("divider started while busy");

  a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |=> !done_r)
    else $error("divider done held longer than one cycle");

  a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> $past(busy_r))
    else $error("divider done without a division in progress");

endmodule

`default_nettype wire

### rtl/core/nearest_neighbor_image_scaler_core.sv
// Nearest-neighbour image scaler: frame store, shared multiplier and divider, sequencer.
// Depends on nns_pkg, nns_ram and nns_div.
//
// Usage: a load word (in_mode 0) writes one BGR pixel into the frame store in
// raster order; busy stays low, so loads may come every cycle. A fetch word
// (in_mode 1) raises busy and runs a sequencer over one shared 16x9 multiplier
// and one shared restoring divider: the output size, the source row and the
// source column are worked out in turn. The result appears with out_valid for
// one cycle; busy is low in that same cycle, so a new word can be taken then.
// A fetch on an empty output size answers with out_status set. The receiver
// cannot stall: take every result in the cycle that out_valid is high.
// Configuration writes land at once and are to be made by the user only while
// the block is idle; the block itself does not enforce this.
`default_nettype none

module nearest_neighbor_image_scaler_core #(
  parameter int MAX_WIDTH            = 256,
  parameter int MAX_HEIGHT           = 256,
  parameter int FACTOR_FRACTION_BITS = 8
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  // command channel
  input  wire logic                            start,
  output logic                                 busy,
  input  wire logic                            in_mode,
  input  wire logic [7:0]                      in_blue,
  input  wire logic [7:0]                      in_green,
  input  wire logic [7:0]                      in_red,
  // result channel
  output logic                                 out_valid,
  output logic [7:0]                           out_blue,
  output logic [7:0]                           out_green,
  output logic [7:0]                           out_red,
  output logic                                 out_last_pixel,
  output logic                                 out_status,
  // configuration
  input  wire logic                            cfg_we,
  input  wire logic [nns_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [nns_pkg::CFG_W-1:0]       cfg_data
);

  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW    = $clog2(DEPTH);
  localparam logic [nns_pkg::NUM_W:0] HALF =
    (nns_pkg::NUM_W + 1)'(2 ** (FACTOR_FRACTION_BITS - 1));

  localparam logic [3:0] ST_IDLE = 4'd0;
  localparam logic [3:0] ST_MW   = 4'd1;
  localparam logic [3:0] ST_MH   = 4'd2;
  localparam logic [3:0] ST_OH   = 4'd3;
  localparam logic [3:0] ST_CHK  = 4'd4;
  localparam logic [3:0] ST_DR   = 4'd5;
  localparam logic [3:0] ST_DRW  = 4'd6;
  localparam logic [3:0] ST_DCW  = 4'd7;
  localparam logic [3:0] ST_ADR  = 4'd8;
  localparam logic [3:0] ST_RD   = 4'd9;
  localparam logic [3:0] ST_OUT  = 4'd10;

  logic [3:0] state_r, state_nxt;

  logic [nns_pkg::SRC_W-1:0] src_width_r;
  logic [nns_pkg::SRC_W-1:0] src_height_r;
  logic [nns_pkg::DIM_W-1:0] scale_r;

  logic [nns_pkg::POS_W-1:0] pos_r;
  logic [nns_pkg::DIM_W-1:0] row_r, col_r;
  logic [nns_pkg::DIM_W-1:0] ow_r, oh_r;
  logic [nns_pkg::SRC_W-1:0] sr_r, sc_r;
  logic [nns_pkg::NUM_W-1:0] prod_r;
  logic                      last_r;

  logic       out_valid_r, out_last_r, out_status_r;
  logic [7:0] out_blue_r, out_green_r, out_red_r;

  // ---------------------------------------------------------------------------
  // effective source size
  logic [nns_pkg::SRC_W-1:0] w_eff, h_eff;
  logic [nns_pkg::IDX_W-1:0] area;

  always_comb begin
    if (src_width_r == '0) begin
      w_eff = nns_pkg::SRC_W'(1);
    end else if (32'(src_width_r) > 32'(MAX_WIDTH)) begin
      w_eff = nns_pkg::SRC_W'(MAX_WIDTH);
    end else begin
      w_eff = src_width_r;
    end
    if (src_height_r == '0) begin
      h_eff = nns_pkg::SRC_W'(1);
    end else if (32'(src_height_r) > 32'(MAX_HEIGHT)) begin
      h_eff = nns_pkg::SRC_W'(MAX_HEIGHT);
    end else begin
      h_eff = src_height_r;
    end
  end

  assign area = nns_pkg::IDX_W'(w_eff) * nns_pkg::IDX_W'(h_eff);

  // ---------------------------------------------------------------------------
  // load path
  logic                      accept, load_fire, fetch_fire;
  logic [nns_pkg::POS_W-1:0] pos_cur;
  logic [nns_pkg::POS_W:0]   pos_inc;
  logic [nns_pkg::POS_W-1:0] pos_nxt;
  logic [31:0]               wr_ext;
  logic [AW-1:0]             wr_addr;

  assign accept     = start && (state_r == ST_IDLE);
  assign load_fire  = accept && !in_mode;
  assign fetch_fire = accept && in_mode;

  // restart a stale position before the write
  assign pos_cur = (nns_pkg::IDX_W'(pos_r) >= area) ? '0 : pos_r;
  assign pos_inc = {1'b0, pos_cur} + 1'b1;
  assign pos_nxt = (nns_pkg::IDX_W'(pos_inc) >= area) ? '0 : pos_inc[nns_pkg::POS_W-1:0];
  assign wr_ext  = 32'(pos_cur);
  assign wr_addr = wr_ext[AW-1:0];

  // ---------------------------------------------------------------------------
  // shared multiplier
  logic [nns_pkg::DIM_W-1:0] mul_a;
  logic [nns_pkg::SRC_W-1:0] mul_b;
  logic                      mul_en;
  logic [nns_pkg::NUM_W-1:0] mul_res;
  logic                      out_of_range;
  logic [nns_pkg::DIM_W-1:0] row_eff, col_eff;

  assign out_of_range = (row_r >= oh_r) || (col_r >= ow_r);
  assign row_eff      = out_of_range ? '0 : row_r;
  assign col_eff      = out_of_range ? '0 : col_r;

  always_comb begin
    mul_a  = scale_r;
    mul_b  = w_eff;
    mul_en = 1'b0;
    unique case (state_r)
      ST_MW: begin
        mul_en = 1'b1;
      end
      ST_MH: begin
        mul_b  = h_eff;
        mul_en = 1'b1;
      end
      ST_CHK: begin
        mul_a  = row_eff;
        mul_b  = h_eff;
        mul_en = 1'b1;
      end
      ST_DR: begin
        mul_a  = col_r;
        mul_en = 1'b1;
      end
      ST_ADR: begin
        mul_a  = nns_pkg::DIM_W'(sr_r);
        mul_en = 1'b1;
      end
      default: begin
        mul_en = 1'b0;
      end
    endcase
  end

  assign mul_res = nns_pkg::NUM_W'(mul_a) * nns_pkg::NUM_W'(mul_b);

  // round half up, drop the fraction, saturate
  logic [nns_pkg::NUM_W:0]   rnd, shf;
  logic [nns_pkg::DIM_W-1:0] dim_scaled;

  assign rnd        = {1'b0, prod_r} + HALF;
  assign shf        = rnd >> FACTOR_FRACTION_BITS;
  assign dim_scaled = (shf > (nns_pkg::NUM_W + 1)'(nns_pkg::DIM_MAX)) ?
                      nns_pkg::DIM_MAX : shf[nns_pkg::DIM_W-1:0];

  // ---------------------------------------------------------------------------
  // shared divider
  nns_pkg::div_req_t div_req;
  nns_pkg::div_rsp_t div_rsp;

  assign div_req.start    = (state_r == ST_DR) || ((state_r == ST_DRW) && div_rsp.done);
  assign div_req.dividend = prod_r;
  assign div_req.divisor  = (state_r == ST_DR) ? oh_r : ow_r;

  nns_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  // ---------------------------------------------------------------------------
  // frame store
  logic [nns_pkg::IDX_W-1:0] rd_idx;
  logic [31:0]               rd_ext;
  logic [AW-1:0]             rd_addr;
  logic [nns_pkg::PIX_W-1:0] rd_data;

  assign rd_idx  = prod_r[nns_pkg::IDX_W-1:0] + nns_pkg::IDX_W'(sc_r);
  assign rd_ext  = 32'(rd_idx);
  assign rd_addr = rd_ext[AW-1:0];

  nns_ram #(
    .WIDTH (nns_pkg::PIX_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (load_fire),
    .wr_addr (wr_addr),
    .wr_data ({in_red, in_green, in_blue}),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // ---------------------------------------------------------------------------
  // sequencer
  logic empty;
  assign empty = (ow_r == '0) || (oh_r == '0);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (fetch_fire) state_nxt = ST_MW;
      ST_MW:   state_nxt = ST_MH;
      ST_MH:   state_nxt = ST_OH;
      ST_OH:   state_nxt = ST_CHK;
      ST_CHK:  state_nxt = empty ? ST_IDLE : ST_DR;
      ST_DR:   state_nxt = ST_DRW;
      ST_DRW:  if (div_rsp.done) state_nxt = ST_DCW;
      ST_DCW:  if (div_rsp.done) state_nxt = ST_ADR;
      ST_ADR:  state_nxt = ST_RD;
      ST_RD:   state_nxt = ST_OUT;
      ST_OUT:  state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  logic [nns_pkg::DIM_W:0] col_inc, row_inc;
  assign col_inc = {1'b0, col_r} + 1'b1;
  assign row_inc = {1'b0, row_r} + 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      src_width_r  <= nns_pkg::SRC_WIDTH_RST;
      src_height_r <= nns_pkg::SRC_HEIGHT_RST;
      scale_r      <= nns_pkg::SCALE_RST;
      pos_r        <= '0;
      row_r        <= '0;
      col_r        <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= 1'b0;

      if (cfg_we) begin
        unique case (cfg_index)
          nns_pkg::CFG_SRC_WIDTH:  src_width_r  <= cfg_data[nns_pkg::SRC_W-1:0];
          nns_pkg::CFG_SRC_HEIGHT: src_height_r <= cfg_data[nns_pkg::SRC_W-1:0];
          nns_pkg::CFG_SCALE:      scale_r      <= cfg_data;
          default: ;
        endcase
      end

      if (load_fire) begin
        pos_r <= pos_nxt;
      end

      if (mul_en) begin
        prod_r <= mul_res;
      end

      unique case (state_r)
        ST_MH: begin
          ow_r <= dim_scaled;
        end
        ST_OH: begin
          oh_r <= dim_scaled;
        end
        ST_CHK: begin
          if (empty) begin
            // empty output: answer with status and leave the counters alone
            out_valid_r  <= 1'b1;
            out_blue_r   <= '0;
            out_green_r  <= '0;
            out_red_r    <= '0;
            out_last_r   <= 1'b0;
            out_status_r <= 1'b1;
          end else begin
            row_r <= row_eff;
            col_r <= col_eff;
          end
        end
        ST_DRW: begin
          if (div_rsp.done) sr_r <= div_rsp.quotient;
        end
        ST_DCW: begin
          if (div_rsp.done) sc_r <= div_rsp.quotient;
        end
        ST_RD: begin
          // advance raster position
          last_r <= 1'b0;
          if (col_inc >= {1'b0, ow_r}) begin
            col_r <= '0;
            if (row_inc >= {1'b0, oh_r}) begin
              row_r  <= '0;
              last_r <= 1'b1;
            end else begin
              row_r <= row_inc[nns_pkg::DIM_W-1:0];
            end
          end else begin
            col_r <= col_inc[nns_pkg::DIM_W-1:0];
          end
        end
        ST_OUT: begin
          out_valid_r  <= 1'b1;
          out_blue_r   <= rd_data[7:0];
          out_green_r  <= rd_data[15:8];
          out_red_r    <= rd_data[23:16];
          out_last_r   <= last_r;
          out_status_r <= 1'b0;
        end
        default: ;
      endcase
    end
  end

  assign busy           = (state_r != ST_IDLE);
  assign out_valid      = out_valid_r;
  assign out_blue       = out_blue_r;
  assign out_green      = out_green_r;
  assign out_red        = out_red_r;
  assign out_last_pixel = out_last_r;
  assign out_status     = out_status_r;

  a_valid_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |=> !out_valid_r)
    else $error("result strobe longer than one cycle");

  a_fetch_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_mode) |=> busy)
    else $error("fetch word taken without entering the sequence");

  a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && !in_mode) |=> !busy && !out_valid_r)
    else $error("load word started a sequence or produced a result");

  a_status_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_status_r) |->
      (!out_last_r && (out_blue_r == 8'd0) && (out_green_r == 8'd0) && (out_red_r == 8'd0)))
    else $error("empty-size result carries pixel data");

  a_out_after_read: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_OUT) |-> $past(state_r == ST_RD))
    else $error("result state entered without a store read");

endmodule

`default_nettype wire

### verif/nearest_neighbor_image_scaler_core_tb.sv
`timescale 1ns / 100ps
// Self-checking bench for nearest_neighbor_image_scaler_core: a queued word
// driver, a monitor with a behavioural scaler predictor and a pixel scoreboard.
// Depends on nns_pkg and the scaler core RTL.

module nearest_neighbor_image_scaler_core_tb;

  localparam int FRAC_BITS     = 8;
  localparam int MAX_W         = 256;
  localparam int MAX_H         = 256;
  localparam int STORE_DEPTH   = MAX_W * MAX_H;
  localparam int SETTLE_CYCLES = 36;
  localparam int STALL_LIMIT   = 1000;
  localparam int TAIL_CYCLES   = 40;
  localparam int ITEM_TARGET   = 1450;
  localparam int QUIET_TAIL    = 150;
  localparam int REPORT_CAP    = 30;

  localparam logic MODE_LOAD  = 1'b0;
  localparam logic MODE_FETCH = 1'b1;
  localparam logic [nns_pkg::CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

  typedef enum logic [1:0] {OP_WORD, OP_CFG, OP_DRAIN} op_kind_t;

  typedef struct {
    op_kind_t                      kind;
    logic                          mode;
    logic [7:0]                    blue;
    logic [7:0]                    green;
    logic [7:0]                    red;
    logic [nns_pkg::CFG_IDX_W-1:0] idx;
    logic [nns_pkg::CFG_W-1:0]     data;
  } op_t;

  typedef struct packed {
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
    logic       last;
    logic       status;
  } pixel_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic in_mode = 1'b0;
  logic [7:0] in_blue = '0;
  logic [7:0] in_green = '0;
  logic [7:0] in_red = '0;
  logic out_valid;
  logic [7:0] out_blue;
  logic [7:0] out_green;
  logic [7:0] out_red;
  logic out_last_pixel;
  logic out_status;
  logic cfg_we = 1'b0;
  logic [nns_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [nns_pkg::CFG_W-1:0] cfg_data = '0;

  always #5 clk = ~clk;

  nearest_neighbor_image_scaler_core dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_mode        (in_mode),
    .in_blue        (in_blue),
    .in_green       (in_green),
    .in_red         (in_red),
    .out_valid      (out_valid),
    .out_blue       (out_blue),
    .out_green      (out_green),
    .out_red        (out_red),
    .out_last_pixel (out_last_pixel),
    .out_status     (out_status),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  op_t    pending[$];
  pixel_t pixels_due[$];

  // predictor state
  bit [nns_pkg::PIX_W-1:0]   frame_copy [0:STORE_DEPTH-1];
  logic [nns_pkg::SRC_W-1:0] width_reg  = nns_pkg::SRC_WIDTH_RST;
  logic [nns_pkg::SRC_W-1:0] height_reg = nns_pkg::SRC_HEIGHT_RST;
  logic [nns_pkg::DIM_W-1:0] scale_reg  = nns_pkg::SCALE_RST;
  int unsigned load_pos, row_pos, col_pos;

  logic word_taken = 1'b0;
  int idle_cycles, stall_cycles, gap_left;
  int mismatches, words_taken, pixels_checked, frames_ended, empty_answers, cfg_writes;

  // stimulus-side view of the settings
  int unsigned gen_w = MAX_W, gen_h = MAX_H;
  logic [nns_pkg::DIM_W-1:0] gen_scale = nns_pkg::SCALE_RST;
  int item_total, settings_used;

  function automatic int unsigned clamp_dim(logic [nns_pkg::SRC_W-1:0] v, int unsigned lim);
    if (v == 0) return 1;
    if (v > lim) return lim;
    return v;
  endfunction

  function automatic int unsigned scaled_dim(int unsigned src,
                                             logic [nns_pkg::DIM_W-1:0] factor);
    longint v;
    v = (longint'(src) * longint'(factor) + (longint'(1) << (FRAC_BITS - 1))) >> FRAC_BITS;
    return (v > 65535) ? 65535 : int'(v);
  endfunction

  function automatic void load_source_pixel(logic [7:0] b, logic [7:0] g, logic [7:0] r);
    int unsigned area;
    area = clamp_dim(width_reg, MAX_W) * clamp_dim(height_reg, MAX_H);
    if (load_pos >= area) load_pos = 0;
    frame_copy[load_pos] = {r, g, b};
    load_pos++;
    if (load_pos >= area) load_pos = 0;
    load_pos &= 32'hFFFF;
  endfunction

  function automatic pixel_t next_scaled_pixel();
    int unsigned w, h, ow, oh, sr, sc;
    logic [nns_pkg::PIX_W-1:0] px;
    pixel_t p;
    w  = clamp_dim(width_reg, MAX_W);
    h  = clamp_dim(height_reg, MAX_H);
    ow = scaled_dim(w, scale_reg);
    oh = scaled_dim(h, scale_reg);
    p  = '0;
    if (ow == 0 || oh == 0) begin
      p.status = 1'b1;
      return p;
    end
    // counters left over from a larger output size restart
    if (row_pos >= oh || col_pos >= ow) begin
      row_pos = 0;
      col_pos = 0;
    end
    sr = (row_pos * h) / oh;
    sc = (col_pos * w) / ow;
    px = frame_copy[(sr * w + sc) % STORE_DEPTH];
    col_pos++;
    if (col_pos >= ow) begin
      col_pos = 0;
      row_pos++;
      if (row_pos >= oh) begin
        row_pos = 0;
        p.last = 1'b1;
      end
    end
    p.blue  = px[7:0];
    p.green = px[15:8];
    p.red   = px[23:16];
    return p;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    mismatches++;
    if (mismatches <= REPORT_CAP)
      $display("%0t ns: %s: got %0h, want %0h", $time, what, got, want);
  endtask

  // ---------------------------------------------------------------- stimulus
  task automatic add_word(logic mode, logic [7:0] b, logic [7:0] g, logic [7:0] r);
    op_t op;
    op.kind  = OP_WORD;
    op.mode  = mode;
    op.blue  = b;
    op.green = g;
    op.red   = r;
    op.idx   = '0;
    op.data  = '0;
    pending.push_back(op);
    item_total++;
  endtask

  task automatic add_cfg(logic [nns_pkg::CFG_IDX_W-1:0] idx, logic [nns_pkg::CFG_W-1:0] data);
    op_t op;
    op.kind  = OP_CFG;
    op.mode  = MODE_LOAD;
    op.blue  = '0;
    op.green = '0;
    op.red   = '0;
    op.idx   = idx;
    op.data  = data;
    pending.push_back(op);
    case (idx)
      nns_pkg::CFG_SRC_WIDTH:  gen_w = clamp_dim(data[nns_pkg::SRC_W-1:0], MAX_W);
      nns_pkg::CFG_SRC_HEIGHT: gen_h = clamp_dim(data[nns_pkg::SRC_W-1:0], MAX_H);
      nns_pkg::CFG_SCALE:      gen_scale = data;
      default: ;
    endcase
  endtask

  task automatic add_drain();
    op_t op;
    op.kind  = OP_DRAIN;
    op.mode  = MODE_LOAD;
    op.blue  = '0;
    op.green = '0;
    op.red   = '0;
    op.idx   = '0;
    op.data  = '0;
    pending.push_back(op);
  endtask

  task automatic add_random_load();
    add_word(MODE_LOAD, 8'($urandom), 8'($urandom), 8'($urandom));
  endtask

  // a whole frame from wherever the load position stands covers every entry
  task automatic add_frame();
    repeat (gen_w * gen_h) add_random_load();
  endtask

  task automatic add_fetches(int n, bit noisy);
    int drain_at;
    drain_at = ($urandom_range(0, 3) == 0) ? $urandom_range(0, n) : -1;
    for (int i = 0; i < n; i++) begin
      if (noisy && $urandom_range(0, 7) == 0) add_random_load();
      if (i == drain_at) add_drain();
      add_word(MODE_FETCH, 8'($urandom), 8'($urandom), 8'($urandom));
    end
  endtask

  initial begin : stimulus
    int unsigned w_raw, h_raw, ow, oh, n;
    int big_phases;
    logic [nns_pkg::DIM_W-1:0] factor;

    // directed: 2x2 source, upper data bits of the width write are dropped
    add_cfg(nns_pkg::CFG_SRC_WIDTH, 16'hFE02);
    add_cfg(nns_pkg::CFG_SRC_HEIGHT, 16'd2);
    add_cfg(nns_pkg::CFG_SCALE, 16'd256);
    add_word(MODE_LOAD, 8'h00, 8'h00, 8'h00);
    add_word(MODE_LOAD, 8'hFF, 8'hFF, 8'hFF);
    add_word(MODE_LOAD, 8'h55, 8'hAA, 8'h55);
    add_word(MODE_LOAD, 8'hAA, 8'h55, 8'hAA);
    add_fetches(5, 1'b0);                    // frame end, then wrap to the top
    add_drain();
    add_cfg(nns_pkg::CFG_SCALE, 16'd512);    // 4x4 output
    add_fetches(6, 1'b0);
    add_cfg(nns_pkg::CFG_SCALE, 16'd128);    // 1x1: counters now out of range
    add_fetches(2, 1'b0);
    add_cfg(nns_pkg::CFG_SCALE, 16'd0);      // empty output
    add_fetches(1, 1'b0);
    add_cfg(nns_pkg::CFG_SCALE, 16'd1);      // rounds down to empty
    add_fetches(1, 1'b0);
    add_cfg(CFG_SPARE, 16'hFFFF);            // unused index, no effect
    add_cfg(nns_pkg::CFG_SCALE, 16'hFFFF);
    add_fetches(2, 1'b0);
    repeat (3) add_random_load();
    add_cfg(nns_pkg::CFG_SRC_WIDTH, 16'd1);  // load position now stale
    add_cfg(nns_pkg::CFG_SRC_HEIGHT, 16'd1);
    add_random_load();
    add_fetches(1, 1'b0);
    settings_used = 8;

    // random phases: mostly small frames, a wide and a tall one
    big_phases = 0;
    while (item_total < ITEM_TARGET) begin
      settings_used++;
      if ($urandom_range(0, 2) != 0 || settings_used == 9) begin
        if (big_phases < 2 && $urandom_range(0, 9) == 0) begin
          if (big_phases == 0) begin
            w_raw = $urandom_range(0, 1) ? 256 : $urandom_range(257, 511);
            h_raw = 1;
          end else begin
            w_raw = $urandom_range(0, 1);
            h_raw = $urandom_range(0, 1) ? 256 : $urandom_range(257, 511);
          end
          big_phases++;
        end else begin
          w_raw = $urandom_range(0, 7);
          h_raw = $urandom_range(0, 7);
        end
        add_cfg(nns_pkg::CFG_SRC_WIDTH, nns_pkg::CFG_W'(w_raw) |
                (nns_pkg::CFG_W'($urandom_range(0, 127)) << nns_pkg::SRC_W));
        add_cfg(nns_pkg::CFG_SRC_HEIGHT, nns_pkg::CFG_W'(h_raw));
        add_frame();
      end
      case ($urandom_range(0, 19))
        0:       factor = '0;
        1:       factor = nns_pkg::DIM_W'($urandom_range(1, 127));
        2:       factor = '1;
        3:       factor = nns_pkg::DIM_W'($urandom_range(1024, 65534));
        default: factor = nns_pkg::DIM_W'($urandom_range(64, 768));
      endcase
      // the wide frame may get a unity scale, so that its frame end is reached
      if (gen_w == MAX_W && gen_h == 1 && $urandom_range(0, 1)) factor = 16'd256;
      add_cfg(nns_pkg::CFG_SCALE, factor);
      ow = scaled_dim(gen_w, gen_scale);
      oh = scaled_dim(gen_h, gen_scale);
      if (ow == 0 || oh == 0) n = $urandom_range(1, 3);
      else if (ow * oh <= 48) n = ow * oh * $urandom_range(1, 2) + $urandom_range(0, 3);
      else if (ow * oh <= 300) n = ow * oh + $urandom_range(0, 3);
      else n = $urandom_range(10, 40);
      add_fetches(n, 1'b1);
    end

    repeat (3) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;

    while (pending.size() != 0 || start || pixels_due.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    while (pixels_due.size() != 0) begin
      void'(pixels_due.pop_front());
      report_mismatch("pixel never returned", 0, 1);
    end

    $display("Covered %0d words over %0d size/scale settings with %0d register writes.",
             words_taken, settings_used, cfg_writes);
    $display("Checked %0d results: %0d frame ends, %0d empty-size answers, %0d mismatches.",
             pixels_checked, frames_ended, empty_answers, mismatches);
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // ------------------------------------------------------------------ driver
  always @(negedge clk) begin : driver
    logic fire, cfg_fire;
    op_t op;
    fire     = 1'b0;
    cfg_fire = 1'b0;
    if (rst_n) begin
      if (start && !word_taken) begin
        fire = 1'b1;                 // hold the word until taken
      end else if (gap_left > 0) begin
        gap_left--;
      end else if (pending.size() != 0) begin
        op = pending[0];
        case (op.kind)
          OP_WORD: begin
            void'(pending.pop_front());
            fire = 1'b1;
            in_mode  <= op.mode;
            in_blue  <= op.blue;
            in_green <= op.green;
            in_red   <= op.red;
            if (pending.size() > QUIET_TAIL && $urandom_range(0, 5) == 0)
              gap_left = $urandom_range(1, 7);
          end
          OP_CFG: begin
            // write only once the block has gone quiet
            if (pixels_due.size() == 0 && !busy && idle_cycles >= SETTLE_CYCLES) begin
              void'(pending.pop_front());
              cfg_fire = 1'b1;
              cfg_index <= op.idx;
              cfg_data  <= op.data;
            end
          end
          default: begin
            if (pixels_due.size() == 0) void'(pending.pop_front());
          end
        endcase
      end
    end
    start  <= fire;
    cfg_we <= cfg_fire;
  end

  // ----------------------------------------------------------------- monitor
  always @(posedge clk) begin : monitor
    pixel_t want;
    if (!rst_n) begin
      word_taken <= 1'b0;
    end else begin
      word_taken <= start && !busy;
      idle_cycles++;
      if (start && !busy) begin
        words_taken++;
        idle_cycles = 0;
        if (in_mode == MODE_LOAD) load_source_pixel(in_blue, in_green, in_red);
        else pixels_due.push_back(next_scaled_pixel());
      end
      if (cfg_we) begin
        cfg_writes++;
        case (cfg_index)
          nns_pkg::CFG_SRC_WIDTH:  width_reg  = cfg_data[nns_pkg::SRC_W-1:0];
          nns_pkg::CFG_SRC_HEIGHT: height_reg = cfg_data[nns_pkg::SRC_W-1:0];
          nns_pkg::CFG_SCALE:      scale_reg  = cfg_data;
          default: ;
        endcase
      end
      if (out_valid) begin
        idle_cycles = 0;
        if (pixels_due.size() == 0) begin
          report_mismatch("result with nothing due", out_blue, 0);
        end else begin
          want = pixels_due.pop_front();
          pixels_checked++;
          if (want.last) frames_ended++;
          if (want.status) empty_answers++;
          if (out_blue !== want.blue) report_mismatch("out_blue", out_blue, want.blue);
          if (out_green !== want.green) report_mismatch("out_green", out_green, want.green);
          if (out_red !== want.red) report_mismatch("out_red", out_red, want.red);
          if (out_last_pixel !== want.last)
            report_mismatch("out_last_pixel", out_last_pixel, want.last);
          if (out_status !== want.status)
            report_mismatch("out_status", out_status, want.status);
        end
      end
    end
  end

  // ---------------------------------------------------------------- watchdog
  always @(posedge clk) begin : watchdog
    if (!rst_n || (start && !busy) || out_valid || cfg_we) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("%0t ns: no progress for %0d cycles", $time, STALL_LIMIT);
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

endmodule
